// ===== hdl/sbs_pkg.sv =====
// Package: table size, fixed-point constants, command codes, register indices and sequencer states.
package sbs_pkg;

  localparam int SPHERE_COUNT = 64;
  localparam int ADDR_W       = (SPHERE_COUNT > 1) ? $clog2(SPHERE_COUNT) : 1;
  localparam int ROW_W        = 32 + 32 + 24 + 1 + 1;

  localparam logic [16:0] ONE_Q16      = 17'd65536;
  localparam logic [17:0] TWO_Q16      = 18'd131072;
  localparam logic [17:0] THREE_Q16    = 18'd196608;
  localparam logic [17:0] PI_Q16       = 18'd205887;
  localparam logic [18:0] FULL_VOL_Q16 = 19'd274517;
  // floor(y/3) = (y * RECIP3) >> 25, exact for y < 2^24
  localparam logic [23:0] RECIP3       = 24'd11184811;

  localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  localparam logic [1:0] REG_SPAWN   = 2'd0;
  localparam logic [1:0] REG_REST    = 2'd1;
  localparam logic [1:0] REG_GRAVITY = 2'd2;
  localparam logic [1:0] REG_DENSITY = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_D2, S_T, S_P, S_V3, S_FB1, S_FB2, S_NET,
    S_DIV, S_QSAT, S_VEL, S_POS, S_WB
  } state_t;

endpackage

// ===== hdl/sphere_buoyancy_step_unit.sv =====
// Top level: sphere table memory, read-modify-write sequencer and shared divider.
// Sphere buoyancy step unit. Holds up to 64 unit-radius spheres (position,
// velocity, mass, in-water and reached-top flags) in one synchronous table
// memory with a registered read. A load beat passes from the accept state
// straight to write-back. A step beat runs through a sequencer of
// single-multiply stages (cap volume, buoyant force, weight), a
// 1-bit-per-cycle restoring divider for the acceleration (then a step to
// sign and saturate), velocity and position updates, and a second pass
// through the same divider when the sphere is held at the wave top. A step
// skips the divider when the acceleration saturates or the mass is zero. A
// stalled result holds the sequencer in write-back. One beat is in work at a
// time; the next input beat is taken while the previous result still waits
// in the output register. All math is signed Q16.16 with saturation. Reset
// clears the flags and motion state through per-row valid bits at once: no
// clearing pass.
module sphere_buoyancy_step_unit (
  input  logic                clk,
  input  logic                rst,
  // configuration
  input  logic                write_enable,
  input  logic [1:0]          reg_index,
  input  logic [31:0]         write_data,
  // input channel
  input  logic                item_valid,
  output logic                item_ready,
  input  logic                command,
  input  logic [5:0]          sphere_index,
  input  logic signed [31:0]  wave_amplitude,
  input  logic [15:0]         time_step,
  input  logic [23:0]         start_mass,
  // result channel
  output logic                result_valid,
  input  logic                result_ready,
  output logic [5:0]          out_index,
  output logic signed [31:0]  position_y,
  output logic signed [31:0]  velocity_y,
  output logic                at_top,
  output logic                splash
);
  import sbs_pkg::*;

  // config registers
  logic signed [31:0] spawn_height;
  logic [11:0]        restitution;
  logic [23:0]        gravity_accel;
  logic [15:0]        water_density;

  always_ff @(posedge clk) begin
    if (rst) begin
      spawn_height  <= '0;
      restitution   <= 12'd435;
      gravity_accel <= 24'd642908;
      water_density <= 16'd1000;
    end else if (write_enable) begin
      unique case (reg_index)
        REG_SPAWN:   spawn_height  <= write_data;
        REG_REST:    restitution   <= write_data[11:0];
        REG_GRAVITY: gravity_accel <= write_data[23:0];
        REG_DENSITY: water_density <= write_data[15:0];
        default: ;
      endcase
    end
  end

  // sphere table: {reached_top, in_water, mass, velocity, position}
  logic [ROW_W-1:0]        table_mem [SPHERE_COUNT];
  logic [SPHERE_COUNT-1:0] row_valid;
  logic [ROW_W-1:0]        rd_row;
  logic                    rd_valid;

  state_t state, state_next;
  logic   accept, wb_go;
  logic   net_div_go, rest_div_go;

  // working registers
  logic [5:0]         idx_r;
  logic               skip_r;
  logic signed [31:0] amp_r;
  logic [15:0]        dt_r;
  logic signed [31:0] pos_r, vel_r, acc_r;
  logic [23:0]        mass_r;
  logic               iw_r, rt_r, top_r, splash_r;
  logic               full_r, part_r;
  logic [16:0]        d_r;
  logic [17:0]        d2_r;
  logic [19:0]        t_r;
  logic [21:0]        y_r;
  logic [18:0]        vol_r;
  logic [34:0]        p1_r;
  logic [58:0]        fb_r;
  logic [47:0]        mg_r;
  // divider
  logic [23:0]        div_rem, div_den;
  logic [31:0]        div_low;
  logic [4:0]         div_cnt;
  logic               div_neg, div_rest;

  assign accept = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    item_ready = 1'b0;
    wb_go      = 1'b0;
    unique case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          if ({26'd0, sphere_index} >= SPHERE_COUNT || command == CMD_LOAD) state_next = S_WB;
          else state_next = S_D2;
        end
      end
      S_D2:  state_next = S_T;
      S_T:   state_next = S_P;
      S_P:   state_next = S_V3;
      S_V3:  state_next = S_FB1;
      S_FB1: state_next = S_FB2;
      S_FB2: state_next = S_NET;
      S_NET: state_next = net_div_go ? S_DIV : S_VEL;
      S_DIV: if (div_cnt == 5'd31) state_next = S_QSAT;
      S_QSAT: state_next = div_rest ? S_WB : S_VEL;
      S_VEL: state_next = S_POS;
      S_POS: state_next = rest_div_go ? S_DIV : S_WB;
      S_WB: begin
        wb_go = !result_valid || result_ready;
        if (wb_go) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    if (v > $signed({2'b00, S32_MAX}))      return S32_MAX;
    else if (v < $signed({2'b11, S32_MIN})) return S32_MIN;
    else                                    return v[31:0];
  endfunction

  // trunc-toward-zero (v * dt) >> 16
  function automatic logic signed [33:0] scale_dt(input logic signed [31:0] v,
                                                  input logic [15:0] dt);
    logic [31:0] mag;
    logic [47:0] prod;
    mag  = v[31] ? 32'(-v) : v;
    prod = mag * dt;
    return v[31] ? -$signed({2'b00, prod[47:16]}) : $signed({2'b00, prod[47:16]});
  endfunction

  // step read data; invalid row reads as reset value
  logic [ROW_W-1:0]   row;
  logic signed [31:0] row_pos;
  logic signed [33:0] depth;
  logic               row_full, row_part;
  assign row      = rd_valid ? rd_row : '0;
  assign row_pos  = row[31:0];
  assign depth    = $signed({1'b0, ONE_Q16}) - $signed({{2{row_pos[31]}}, row_pos});
  assign row_full = depth >= $signed({16'd0, TWO_Q16});
  assign row_part = (depth > 0) && !row_full;

  // cap volume products at full width
  logic [33:0] d_sq;
  logic [35:0] t_prod;
  logic [37:0] y_prod;
  logic [45:0] v_prod;
  assign d_sq   = depth[16:0] * depth[16:0];
  assign t_prod = d2_r * (THREE_Q16 - {1'b0, d_r});
  assign y_prod = t_r * PI_Q16;
  assign v_prod = y_r * RECIP3;

  // net force and acceleration divider setup
  logic signed [60:0] net;
  logic [59:0]        net_mag;
  assign net        = $signed({2'b00, fb_r}) - $signed({13'd0, mg_r});
  assign net_mag    = net[60] ? 60'(-net) : net[59:0];
  assign net_div_go = (mass_r != '0) && (net_mag < {4'd0, mass_r, 32'd0});

  // velocity, position and wave-top decision
  logic               top_now, rt_new;
  logic signed [31:0] pos_new;
  logic [31:0]        vel_mag;
  logic [39:0]        bounce_mag;
  logic               bounce;
  assign top_now     = !rt_r && (vel_r > 0) && (pos_r >= amp_r);
  assign pos_new     = top_now ? pos_r
                       : sat34($signed({{2{pos_r[31]}}, pos_r}) + scale_dt(vel_r, dt_r));
  assign rt_new      = (rt_r || top_now) && !vel_r[31];
  assign vel_mag     = vel_r[31] ? 32'(-vel_r) : vel_r;
  assign bounce_mag  = {vel_mag, 8'd0};
  assign bounce      = top_now && (restitution != '0);
  // divide only when the quotient fits in 32 bits
  assign rest_div_go = bounce && ({24'd0, bounce_mag} < {20'd0, restitution, 32'd0});

  // restoring divider step
  logic [24:0] div_try;
  logic        div_ge;
  assign div_try = {div_rem, div_low[31]};
  assign div_ge  = div_try >= {1'b0, div_den};

  // quotient with sign and saturation
  logic signed [31:0] q_sat;
  always_comb begin
    if (!div_neg) q_sat = div_low[31] ? S32_MAX : div_low;
    else          q_sat = (div_low > S32_MIN) ? S32_MIN : 32'(-div_low);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_row <= table_mem[sphere_index[ADDR_W-1:0]];
      rd_valid <= row_valid[sphere_index[ADDR_W-1:0]];
    end
    if (wb_go && !skip_r)
      table_mem[idx_r[ADDR_W-1:0]] <= {rt_r, iw_r, mass_r, vel_r, pos_r};
  end

  always_ff @(posedge clk) begin
    if (rst) row_valid <= '0;
    else if (wb_go && !skip_r) row_valid[idx_r[ADDR_W-1:0]] <= 1'b1;
  end

  // datapath sequencing
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (accept) begin
        idx_r    <= sphere_index;
        amp_r    <= wave_amplitude;
        dt_r     <= time_step;
        skip_r   <= {26'd0, sphere_index} >= SPHERE_COUNT;
        top_r    <= 1'b0;
        splash_r <= 1'b0;
        vel_r    <= '0;
        pos_r    <= ({26'd0, sphere_index} >= SPHERE_COUNT) ? '0 : spawn_height;
        mass_r   <= start_mass;
        iw_r     <= 1'b0;
        rt_r     <= 1'b0;
      end
      S_D2: begin
        pos_r    <= row[31:0];
        vel_r    <= row[63:32];
        mass_r   <= row[87:64];
        rt_r     <= row[89];
        iw_r     <= row_full ? 1'b1 : (row_part ? 1'b0 : row[88]);
        splash_r <= row_full && !row[88];
        full_r   <= row_full;
        part_r   <= row_part;
        d_r      <= depth[16:0];
        d2_r     <= d_sq[33:16];
        mg_r     <= row[87:64] * gravity_accel;
      end
      S_T: t_r <= t_prod[35:16];
      S_P: y_r <= y_prod[37:16];
      S_V3: begin
        if (full_r)      vol_r <= FULL_VOL_Q16;
        else if (part_r) vol_r <= v_prod[43:25];
        else             vol_r <= '0;
      end
      S_FB1: p1_r <= water_density * vol_r;
      S_FB2: fb_r <= p1_r * gravity_accel;
      S_NET: begin
        if (mass_r == '0)
          acc_r <= net[60] ? S32_MIN : ((net != '0) ? S32_MAX : '0);
        else if (!net_div_go)
          acc_r <= net[60] ? S32_MIN : S32_MAX;
        div_rem  <= net_mag[55:32];
        div_low  <= net_mag[31:0];
        div_den  <= mass_r;
        div_neg  <= net[60];
        div_rest <= 1'b0;
        div_cnt  <= '0;
      end
      S_DIV: begin
        div_rem <= div_ge ? 24'(div_try - {1'b0, div_den}) : div_try[23:0];
        div_low <= {div_low[30:0], div_ge};
        div_cnt <= div_cnt + 5'd1;
      end
      S_QSAT: begin
        if (div_rest) vel_r <= q_sat;
        else          acc_r <= q_sat;
      end
      S_VEL: vel_r <= sat34($signed({{2{vel_r[31]}}, vel_r}) + scale_dt(acc_r, dt_r));
      S_POS: begin
        pos_r <= pos_new;
        rt_r  <= rt_new;
        top_r <= top_now;
        if (bounce && !rest_div_go) vel_r <= vel_r[31] ? S32_MIN : S32_MAX;
        div_rem  <= 24'(bounce_mag[39:32]);
        div_low  <= bounce_mag[31:0];
        div_den  <= {12'd0, restitution};
        div_neg  <= vel_r[31];
        div_rest <= 1'b1;
        div_cnt  <= '0;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else if (wb_go) result_valid <= 1'b1;
    else if (result_ready) result_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (wb_go) begin
      out_index  <= idx_r;
      position_y <= pos_r;
      velocity_y <= vel_r;
      at_top     <= top_r;
      splash     <= splash_r;
    end
  end

endmodule

// ===== hdl/sbs_checker.sv =====
// Port-level checker for the sphere buoyancy step unit, with its bind.
module sbs_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [31:0] position_y
);
  import sbs_pkg::*;

  // held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(position_y))
    else $error("result changed while stalled");

  // one beat in work at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("input taken while busy");

  // no result right out of reset
  a_rst: assert property (@(posedge clk) $past(rst) |-> !result_valid)
    else $error("result valid after reset");

endmodule

bind sphere_buoyancy_step_unit sbs_checker u_sbs_checker (
  .clk(clk), .rst(rst), .item_valid(item_valid), .item_ready(item_ready),
  .result_valid(result_valid), .result_ready(result_ready), .position_y(position_y)
);

// ===== sim/testbench.sv =====
// Testbench for the sphere buoyancy step unit: random and directed beats, scoreboard check.
`timescale 1ns / 100ps

module testbench;
  import sbs_pkg::*;

  typedef struct {
    logic        cmd;
    logic [5:0]  idx;
    logic [31:0] amp;
    logic [15:0] dt;
    logic [23:0] mass;
  } sphere_cmd_t;

  typedef struct {
    logic [5:0]  idx;
    logic [31:0] pos;
    logic [31:0] vel;
    logic        top;
    logic        spl;
  } motion_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic write_enable = 1'b0;
  logic [1:0] reg_index = REG_SPAWN;
  logic [31:0] write_data = '0;
  logic item_valid = 1'b0;
  logic item_ready;
  logic command = CMD_LOAD;
  logic [5:0] sphere_index = '0;
  logic signed [31:0] wave_amplitude = '0;
  logic [15:0] time_step = '0;
  logic [23:0] start_mass = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic [5:0] out_index;
  logic signed [31:0] position_y;
  logic signed [31:0] velocity_y;
  logic at_top;
  logic splash;

  sphere_buoyancy_step_unit DUT (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor copy of the sphere table and registers
  logic signed [31:0] tbl_pos [SPHERE_COUNT];
  logic signed [31:0] tbl_vel [SPHERE_COUNT];
  logic [23:0]        tbl_mass [SPHERE_COUNT];
  logic               tbl_wet [SPHERE_COUNT];
  logic               tbl_top [SPHERE_COUNT];
  logic signed [31:0] cfg_spawn = 0;
  logic [11:0]        cfg_rest = 12'd435;
  logic [23:0]        cfg_grav = 24'd642908;
  logic [15:0]        cfg_dens = 16'd1000;

  sphere_cmd_t pending_cmds[$];
  motion_t     motion_due[$];
  bit          loaded [SPHERE_COUNT];
  int          errors = 0;
  bit          no_idle = 0;
  bit          hold_req = 0;
  int          hold_left = 0;
  bit          took = 0;

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return S32_MAX;
    if (v < -64'sd2147483648) return S32_MIN;
    return v[31:0];
  endfunction

  // (a*b)/den, truncating toward zero
  function automatic longint scale_trunc(longint a, longint unsigned b,
                                         longint unsigned den);
    longint unsigned mag;
    longint unsigned q;
    mag = (a < 0) ? longint'(-a) : a;
    q = (mag * b) / den;
    return (a < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic motion_t advance_sphere(sphere_cmd_t c);
    motion_t r;
    longint depth, vol, net, acc, vel, pos;
    longint unsigned d, d2, t, fb, mg;
    logic [23:0] m;
    r.idx = c.idx; r.pos = '0; r.vel = '0; r.top = 0; r.spl = 0;
    if (c.cmd == CMD_LOAD) begin
      tbl_pos[c.idx] = cfg_spawn;
      tbl_vel[c.idx] = 0;
      tbl_mass[c.idx] = c.mass;
      tbl_wet[c.idx] = 0;
      tbl_top[c.idx] = 0;
      r.pos = cfg_spawn;
      return r;
    end
    pos = tbl_pos[c.idx];
    vel = tbl_vel[c.idx];
    m = tbl_mass[c.idx];
    depth = 65536 - pos;
    vol = 0;
    if (depth > 0) begin
      if (depth >= 131072) begin
        if (!tbl_wet[c.idx]) begin
          r.spl = 1;
          tbl_wet[c.idx] = 1;
        end
        vol = FULL_VOL_Q16;
      end else begin
        d = depth;
        d2 = (d * d) >> 16;
        t = (d2 * longint'(196608 - depth)) >> 16;
        vol = (t * 205887) / 196608;
        tbl_wet[c.idx] = 0;
      end
    end
    // force product stays below 2^59 even at the largest settings
    fb = longint'(cfg_dens) * longint'(vol) * longint'(cfg_grav);
    mg = longint'(m) * longint'(cfg_grav);
    net = longint'(fb) - longint'(mg);
    if (m == 0) acc = (net > 0) ? 64'sd2147483647 : ((net < 0) ? -64'sd2147483648 : 0);
    else acc = sat32(scale_trunc(net, 1, m));
    vel = sat32(vel + scale_trunc(acc, c.dt, 65536));
    if (!tbl_top[c.idx] && vel > 0 && pos >= $signed(c.amp)) begin
      tbl_top[c.idx] = 1;
      r.top = 1;
    end else pos = sat32(pos + scale_trunc(vel, c.dt, 65536));
    if (tbl_top[c.idx] && vel < 0) tbl_top[c.idx] = 0;
    if (r.top && cfg_rest != 0) vel = sat32(scale_trunc(vel, 256, cfg_rest));
    tbl_pos[c.idx] = pos[31:0];
    tbl_vel[c.idx] = vel[31:0];
    r.pos = pos[31:0];
    r.vel = vel[31:0];
    return r;
  endfunction

  // driver: new beat at the falling edge once the last one was taken
  always @(negedge clk) begin
    sphere_cmd_t c;
    if (!item_valid || took) begin
      if (pending_cmds.size() > 0 && (no_idle || $urandom_range(0, 99) >= 13)) begin
        c = pending_cmds.pop_front();
        command <= c.cmd;
        sphere_index <= c.idx;
        wave_amplitude <= c.amp;
        time_step <= c.dt;
        start_mass <= c.mass;
        item_valid <= 1'b1;
      end else item_valid <= 1'b0;
    end
  end

  // receiver: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      result_ready <= 1'b0;
    end else result_ready <= no_idle || $urandom_range(0, 99) >= 13;
  end

  // monitor: check results, predict on accepted input beats
  always @(posedge clk) begin
    motion_t got, want;
    sphere_cmd_t c;
    took <= item_valid && item_ready && !rst;
    if (!rst && result_valid && result_ready) begin
      got.idx = out_index; got.pos = position_y; got.vel = velocity_y;
      got.top = at_top; got.spl = splash;
      if (motion_due.size() == 0) begin
        $display("%0t: unexpected result idx %0d pos %h vel %h", $time,
                 got.idx, got.pos, got.vel);
        errors++;
      end else begin
        want = motion_due.pop_front();
        if (got != want) begin
          $display("%0t: mismatch exp idx %0d pos %h vel %h top %b spl %b", $time,
                   want.idx, want.pos, want.vel, want.top, want.spl);
          $display("%0t:          act idx %0d pos %h vel %h top %b spl %b", $time,
                   got.idx, got.pos, got.vel, got.top, got.spl);
          errors++;
        end
      end
    end
    if (!rst && item_valid && item_ready) begin
      c.cmd = command; c.idx = sphere_index; c.amp = wave_amplitude;
      c.dt = time_step; c.mass = start_mass;
      motion_due = {motion_due, advance_sphere(c)};
    end
  end

  task automatic queue_cmd(logic cmd, logic [5:0] idx, logic [31:0] amp,
                           logic [15:0] dt, logic [23:0] mass);
    sphere_cmd_t c;
    c.cmd = cmd; c.idx = idx; c.amp = amp; c.dt = dt; c.mass = mass;
    if (cmd == CMD_LOAD) loaded[idx] = 1;
    pending_cmds = {pending_cmds, c};
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    write_enable <= 1'b1;
    reg_index <= idx;
    write_data <= val;
    case (idx)
      REG_SPAWN:   cfg_spawn = val;
      REG_REST:    cfg_rest = val[11:0];
      REG_GRAVITY: cfg_grav = val[23:0];
      default:     cfg_dens = val[15:0];
    endcase
    @(negedge clk);
    write_enable <= 1'b0;
  endtask

  task automatic set_phase(logic [31:0] spawn, logic [11:0] rest, logic [23:0] grav,
                           logic [15:0] dens);
    write_reg(REG_SPAWN, spawn);
    write_reg(REG_REST, {20'd0, rest});
    write_reg(REG_GRAVITY, {8'd0, grav});
    write_reg(REG_DENSITY, {16'd0, dens});
  endtask

  // sender stays quiet until the table has nothing in flight
  task automatic drain();
    wait (pending_cmds.size() == 0 && !item_valid && motion_due.size() == 0);
    repeat (100) @(posedge clk);
  endtask

  // mostly load-then-step runs on loaded spheres, some wild values
  task automatic random_beats(int count);
    logic [5:0] s;
    logic [31:0] amp;
    logic [15:0] dt;
    repeat (count) begin
      s = 6'($urandom_range(0, SPHERE_COUNT - 1));
      if (!loaded[s] || $urandom_range(0, 99) < 15) begin
        queue_cmd(CMD_LOAD, s, $urandom, 16'($urandom),
                  ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(1, 400000)));
      end else begin
        amp = ($urandom_range(0, 4) == 0) ? $urandom
              : 32'($signed($urandom_range(0, 6 * 65536)) - 3 * 65536);
        dt = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6000));
        queue_cmd(CMD_STEP, s, amp, dt, 24'($urandom));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < SPHERE_COUNT; i++) begin
      tbl_pos[i] = 0; tbl_vel[i] = 0; tbl_mass[i] = 0;
      tbl_wet[i] = 0; tbl_top[i] = 0; loaded[i] = 0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // deep spawn: full immersion, splash, bounce at wave top
    set_phase(32'hFFFE_0000, 12'd435, 24'd642908, 16'd1000);
    queue_cmd(CMD_LOAD, 0, 0, 0, 24'd65536);
    queue_cmd(CMD_STEP, 0, S32_MAX, 16'hFFFF, 0);
    queue_cmd(CMD_STEP, 0, S32_MAX, 16'd4000, 0);
    queue_cmd(CMD_STEP, 0, S32_MIN, 16'd4000, 0);
    queue_cmd(CMD_STEP, 0, S32_MIN, 16'd4000, 0);
    queue_cmd(CMD_LOAD, 63, S32_MAX, 16'hFFFF, 24'hFFFFFF);
    queue_cmd(CMD_STEP, 63, S32_MIN, 16'd0, 0);
    queue_cmd(CMD_STEP, 63, 32'hFFFE_0000, 16'hFFFF, 24'hFFFFFF);
    queue_cmd(CMD_LOAD, 1, 0, 0, 24'd0);        // zero mass
    queue_cmd(CMD_STEP, 1, S32_MAX, 16'd1000, 0);
    queue_cmd(CMD_STEP, 1, S32_MIN, 16'd1000, 0);
    queue_cmd(CMD_LOAD, 2, 0, 0, 24'd4000000);
    queue_cmd(CMD_STEP, 2, S32_MIN, 16'd20000, 0);
    queue_cmd(CMD_STEP, 2, S32_MIN, 16'd20000, 0);
    queue_cmd(CMD_STEP, 2, 32'h0001_0000, 16'd30000, 0);
    queue_cmd(CMD_STEP, 2, 32'h0001_0000, 16'd30000, 0);
    no_idle = 1;
    random_beats(90);
    drain();
    no_idle = 0;

    // surface spawn, no gravity or density: long receiver hold-off fills the pipe
    set_phase(32'h0000_0000, 12'd256, 24'd0, 16'd0);
    hold_req = 1;
    random_beats(110);
    drain();

    // everything at the top of range: no immersion, largest settings
    set_phase(S32_MAX, 12'd4095, 24'hFFFFFF, 16'hFFFF);
    random_beats(100);
    drain();

    // zero restitution, deepest spawn
    set_phase(S32_MIN, 12'd0, 24'($urandom), 16'd1);
    random_beats(100);
    drain();

    // restitution below one and a random spawn near the surface
    set_phase(32'($signed($urandom_range(0, 4 * 65536)) - 2 * 65536), 12'd100,
              24'd642908, 16'd1);
    random_beats(120);
    drain();

    if (errors == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

  initial begin
    #4000000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
